// ----- rtl/ipd_pkg.sv -----
// Shared constants, types and codes of the pulse-distance infrared decoder.
package ipd_pkg;

  localparam int HALF_BITS = 15;
  localparam int DUR_W     = 16;
  localparam int POS_W     = 6;
  localparam int ADDR_W    = 5;
  localparam int CMD_W     = 8;
  localparam int XCHK_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [POS_W-1:0] POS_PAUSE_MARK   = POS_W'(2 * HALF_BITS);
  localparam logic [POS_W-1:0] POS_PAUSE_SPACE  = POS_W'(2 * HALF_BITS + 1);
  localparam logic [POS_W-1:0] POS_SECOND_START = POS_W'(2 * HALF_BITS + 2);
  localparam logic [POS_W-1:0] POS_CLOSE        = POS_W'(4 * HALF_BITS + 2);

  localparam logic [DUR_W-1:0] MARK_NOM_RST  = DUR_W'(320);
  localparam logic [DUR_W-1:0] ZERO_NOM_RST  = DUR_W'(680);
  localparam logic [DUR_W-1:0] ONE_NOM_RST   = DUR_W'(1680);
  localparam logic [DUR_W-1:0] PAUSE_NOM_RST = DUR_W'(40000);

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_TIMING = 2'd1,
    ST_CHECK  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MARK_NOM  = 2'd0,
    REG_ZERO_NOM  = 2'd1,
    REG_ONE_NOM   = 2'd2,
    REG_PAUSE_NOM = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DUR_W-1:0] mark_nom;
    logic [DUR_W-1:0] zero_nom;
    logic [DUR_W-1:0] one_nom;
    logic [DUR_W-1:0] pause_nom;
  } cfg_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] address;
    logic [CMD_W-1:0]  command;
  } result_t;

endpackage

// ----- rtl/ipd_window.sv -----
// Tolerance window test of one duration against one nominal value.
module ipd_window (
  input  logic [ipd_pkg::DUR_W-1:0] dur,
  input  logic [ipd_pkg::DUR_W-1:0] nom,
  output logic                      ok
);
  import ipd_pkg::*;

  logic [DUR_W+1:0] dur_x2;
  logic [DUR_W+1:0] nom_x3;
  logic             lo_ok;
  logic             hi_ok;

  assign dur_x2 = {1'b0, dur, 1'b0};
  assign nom_x3 = {1'b0, nom, 1'b0} + {2'b00, nom};
  assign lo_ok  = dur >= {1'b0, nom[DUR_W-1:1]};
  assign hi_ok  = dur_x2 <= nom_x3;
  assign ok     = lo_ok & hi_ok;

endmodule

// ----- rtl/ipd_core.sv -----
// Frame state and per-duration decode step of the infrared decoder.
module ipd_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic                      level,
  input  logic [ipd_pkg::DUR_W-1:0] dur,
  input  ipd_pkg::cfg_t             cfg,
  output logic                      emit,
  output ipd_pkg::result_t          res
);
  import ipd_pkg::*;

  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [HALF_BITS-1:0] first_r, first_nxt;
  logic [HALF_BITS-1:0] second_r, second_nxt;

  logic mark_ok, zero_ok, one_ok, pause_ok;
  logic expect_space;
  logic bit_val;
  logic check_ok;

  ipd_window u_mark  (.dur(dur), .nom(cfg.mark_nom),  .ok(mark_ok));
  ipd_window u_zero  (.dur(dur), .nom(cfg.zero_nom),  .ok(zero_ok));
  ipd_window u_one   (.dur(dur), .nom(cfg.one_nom),   .ok(one_ok));
  ipd_window u_pause (.dur(dur), .nom(cfg.pause_nom), .ok(pause_ok));

  assign expect_space = pos_r[0];
  assign bit_val      = ~zero_ok;

  assign check_ok =
    (first_r[ADDR_W-1:0] == second_r[ADDR_W-1:0]) &&
    (first_r[ADDR_W+CMD_W-1:ADDR_W] == ~second_r[ADDR_W+CMD_W-1:ADDR_W]) &&
    (first_r[HALF_BITS-1:ADDR_W+CMD_W] == ~second_r[HALF_BITS-1:ADDR_W+CMD_W]);

  always_comb begin
    emit        = 1'b0;
    res.status  = ST_TIMING;
    res.address = '0;
    res.command = '0;
    pos_nxt     = pos_r + POS_W'(1);
    first_nxt   = first_r;
    second_nxt  = second_r;
    if (level != expect_space) begin
      emit = 1'b1;
    end else if (!expect_space) begin
      if (!mark_ok) begin
        emit = 1'b1;
      end else if (pos_r == POS_CLOSE) begin
        emit        = 1'b1;
        res.status  = check_ok ? ST_OK : ST_CHECK;
        res.address = first_r[ADDR_W-1:0];
        res.command = first_r[ADDR_W+CMD_W-1:ADDR_W];
      end
    end else if (pos_r == POS_PAUSE_SPACE) begin
      if (!pause_ok) begin
        emit = 1'b1;
      end
    end else if (!zero_ok && !one_ok) begin
      emit = 1'b1;
    end else if (pos_r < POS_PAUSE_MARK) begin
      first_nxt = {first_r[HALF_BITS-2:0], bit_val};
    end else if (pos_r >= POS_SECOND_START) begin
      second_nxt = {second_r[HALF_BITS-2:0], bit_val};
    end
    if (emit) begin
      pos_nxt    = '0;
      first_nxt  = '0;
      second_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      first_r  <= '0;
      second_r <= '0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

// ----- rtl/ir_pulse_distance_decoder_top.sv -----
// Top level of the pulse-distance infrared decoder: registers, ports, core.
//
// Usage: feed measured durations (in_level 0 mark, 1 space; in_duration_us
// in microseconds) on the in_ channel. One word is accepted per cycle when
// in_valid is high and in_stall is low. After a complete frame, or at the
// first timing or level error, one result word (out_status, out_address,
// out_command) is offered on the out_ channel and the decoder restarts.
// The duration that ends a frame passes the input register, its result
// word the result register, before out_valid rises. One duration is
// decoded per cycle by the single decode step between the two registers
// while no held result stalls the input. When the receiver holds
// out_stall, the result word holds; one more duration is taken into the
// input register if it is empty, and in_stall rises once it holds a word.
// Nominal durations are written through cfg_ (always ready); the user is
// to write them only while the decoder is idle, which the block does not
// enforce. Reset clears the frame state and both valid flags and restores the default nominal values.
module ir_pulse_distance_decoder_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_level,
  input  logic [ipd_pkg::DUR_W-1:0]         in_duration_us,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [ipd_pkg::ADDR_W-1:0]        out_address,
  output logic [ipd_pkg::CMD_W-1:0]         out_command,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ipd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ipd_pkg::DUR_W-1:0]         cfg_data
);
  import ipd_pkg::*;

  cfg_t             cfg_r;
  logic             in_vld_r;
  logic             level_r;
  logic [DUR_W-1:0] dur_r;
  logic             out_vld_r;
  result_t          res_r;
  logic             adv;
  logic             step;
  logic             emit;
  result_t          res;

  assign adv       = !out_vld_r || !out_stall;
  assign step      = in_vld_r && adv;
  assign in_stall  = in_vld_r && !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mark_nom  <= MARK_NOM_RST;
      cfg_r.zero_nom  <= ZERO_NOM_RST;
      cfg_r.one_nom   <= ONE_NOM_RST;
      cfg_r.pause_nom <= PAUSE_NOM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MARK_NOM:  cfg_r.mark_nom  <= cfg_data;
        REG_ZERO_NOM:  cfg_r.zero_nom  <= cfg_data;
        REG_ONE_NOM:   cfg_r.one_nom   <= cfg_data;
        REG_PAUSE_NOM: cfg_r.pause_nom <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      level_r <= in_level;
      dur_r   <= in_duration_us;
    end
  end

  ipd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .level (level_r),
    .dur   (dur_r),
    .cfg   (cfg_r),
    .emit  (emit),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      res_r <= res;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_status  = res_r.status;
  assign out_address = res_r.address;
  assign out_command = res_r.command;

endmodule
